// ===== sv/crc16_command_frame_checker_core_assert.svh =====
// ---------------------------------------------------------------------------
// crc16 command frame checker assertion macros
// concurrent check wrappers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef CRC16_COMMAND_FRAME_CHECKER_CORE_ASSERT_SVH
`define CRC16_COMMAND_FRAME_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define CRC16CFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc16cfc assertion failed");

`define CRC16CFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc16cfc assertion failed");

`else

`define CRC16CFC_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define CRC16CFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/crc16cfc_pkg.sv =====
// ---------------------------------------------------------------------------
// crc16 command frame checker package
// shared widths, codes, result type and the crc byte update
// ---------------------------------------------------------------------------
package crc16cfc_pkg;

    localparam int FRAME_LEN_DEFAULT = 10;
    localparam int POS_W             = 4;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 8;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [7:0] SYNC_FIRST_RESET  = 8'h1b;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h10;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_SYNC  = 2'd2;
    localparam logic [1:0] STATUS_CRC   = 2'd3;

    typedef struct packed {
        logic [1:0] frame_status;
        logic [7:0] lead_byte;
        logic [7:0] command_code;
        logic [7:0] argument_byte;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/crc16cfc_in_if.sv =====
// ---------------------------------------------------------------------------
// crc16 command frame checker input channel
// one received byte per word with its burst end flag
// ---------------------------------------------------------------------------
interface crc16cfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

// ===== sv/crc16cfc_out_if.sv =====
// ---------------------------------------------------------------------------
// crc16 command frame checker output channel
// one frame report per word
// ---------------------------------------------------------------------------
interface crc16cfc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] frame_status;
    logic [7:0] lead_byte;
    logic [7:0] command_code;
    logic [7:0] argument_byte;

    modport source (output valid, output frame_status, output lead_byte,
                    output command_code, output argument_byte, input ready);
    modport sink   (input valid, input frame_status, input lead_byte,
                    input command_code, input argument_byte, output ready);
endinterface

// ===== sv/crc16_command_frame_checker_core.sv =====
// ---------------------------------------------------------------------------
// crc16 command frame checker core
// checks sync bytes and crc-16 of byte-serial command frames
// ---------------------------------------------------------------------------
// usage
//   in_ch carries one received byte per word plus a burst end flag; the
//   word with burst_end high closes the burst and produces one report.
//   out_ch carries the report: status, and frame bytes 2, 3 and 4.
//   bytes 0 and 1 are compared with the sync registers, the crc-16
//   (0x8005, zero start, msb first) runs over bytes 2 to FRAME_LEN-1,
//   bytes past FRAME_LEN are dropped. cfg_we / cfg_index / cfg_data write the
//   sync registers; the user must write them only while idle (not enforced).
// timing
//   one byte per cycle unless a report stalls; the crc byte update is xor
//   logic between the frame state registers. the report is valid in the
//   cycle after its last byte is accepted, held in one output register.
//   while a report waits on a low out_ch.ready, in_ch.ready is low; a
//   report taken in the same cycle frees room for the next byte at once.
// reset
//   rst_n clears the frame state and the output register, and loads the
//   sync registers with 0x1b and 0x10.
// ---------------------------------------------------------------------------
`include "crc16_command_frame_checker_core_assert.svh"

module crc16_command_frame_checker_core #(
    parameter int FRAME_LEN = crc16cfc_pkg::FRAME_LEN_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    crc16cfc_in_if.sink                         in_ch,
    crc16cfc_out_if.source                      out_ch,
    input  logic                                cfg_we,
    input  logic [crc16cfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crc16cfc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [crc16cfc_pkg::POS_W-1:0] FrameLenPos = crc16cfc_pkg::POS_W'(FRAME_LEN);

    logic [7:0]                     sync_first_reg;
    logic [7:0]                     sync_second_reg;

    logic [crc16cfc_pkg::POS_W-1:0] pos_reg,      pos_next,      pos_upd;
    logic [15:0]                    crc_reg,      crc_next,      crc_upd;
    logic                           mismatch_reg, mismatch_next, mismatch_upd;
    logic [7:0]                     cap_reg  [3];
    logic [7:0]                     cap_next [3];
    logic [7:0]                     cap_upd  [3];

    crc16cfc_pkg::result_t          out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    logic                           in_take;
    logic                           last_take;
    logic [1:0]                     status;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= crc16cfc_pkg::SYNC_FIRST_RESET;
            sync_second_reg <= crc16cfc_pkg::SYNC_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == crc16cfc_pkg::REG_SYNC_FIRST)
            begin
                sync_first_reg <= cfg_data[7:0];
            end
            else if (cfg_index == crc16cfc_pkg::REG_SYNC_SECOND)
            begin
                sync_second_reg <= cfg_data[7:0];
            end
        end
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;
    assign last_take   = in_take && in_ch.burst_end;

    // frame state update for the incoming word
    always_comb
    begin
        pos_upd      = pos_reg;
        crc_upd      = crc_reg;
        mismatch_upd = mismatch_reg;
        for (int i = 0; i < 3; i++)
        begin
            cap_upd[i] = cap_reg[i];
        end
        if (pos_reg < FrameLenPos)
        begin
            if (pos_reg == crc16cfc_pkg::POS_W'(0) && in_ch.rx_byte != sync_first_reg)
            begin
                mismatch_upd = 1'b1;
            end
            if (pos_reg == crc16cfc_pkg::POS_W'(1) && in_ch.rx_byte != sync_second_reg)
            begin
                mismatch_upd = 1'b1;
            end
            if (pos_reg >= crc16cfc_pkg::POS_W'(2))
            begin
                crc_upd = crc16cfc_pkg::crc16_byte(crc_reg, in_ch.rx_byte);
                if (pos_reg <= crc16cfc_pkg::POS_W'(4))
                begin
                    cap_upd[2'(pos_reg - crc16cfc_pkg::POS_W'(2))] = in_ch.rx_byte;
                end
            end
            pos_upd = pos_reg + crc16cfc_pkg::POS_W'(1);
        end
    end

    always_comb
    begin
        priority if (pos_upd < FrameLenPos)
        begin
            status = crc16cfc_pkg::STATUS_SHORT;
        end
        else if (mismatch_upd)
        begin
            status = crc16cfc_pkg::STATUS_SYNC;
        end
        else if (crc_upd != 16'h0000)
        begin
            status = crc16cfc_pkg::STATUS_CRC;
        end
        else
        begin
            status = crc16cfc_pkg::STATUS_OK;
        end
    end

    // next state and report register
    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        mismatch_next  = mismatch_reg;
        for (int i = 0; i < 3; i++)
        begin
            cap_next[i] = cap_reg[i];
        end
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if (in_take)
        begin
            if (in_ch.burst_end)
            begin
                pos_next      = '0;
                crc_next      = '0;
                mismatch_next = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    cap_next[i] = '0;
                end
                out_next.frame_status  = status;
                out_next.lead_byte     = cap_upd[0];
                out_next.command_code  = cap_upd[1];
                out_next.argument_byte = cap_upd[2];
                out_valid_next         = 1'b1;
            end
            else
            begin
                pos_next      = pos_upd;
                crc_next      = crc_upd;
                mismatch_next = mismatch_upd;
                for (int i = 0; i < 3; i++)
                begin
                    cap_next[i] = cap_upd[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            crc_reg       <= '0;
            mismatch_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cap_reg[i] <= '0;
            end
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            mismatch_reg  <= mismatch_next;
            for (int i = 0; i < 3; i++)
            begin
                cap_reg[i] <= cap_next[i];
            end
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.frame_status  = out_reg.frame_status;
    assign out_ch.lead_byte     = out_reg.lead_byte;
    assign out_ch.command_code  = out_reg.command_code;
    assign out_ch.argument_byte = out_reg.argument_byte;

    // checks
    `CRC16CFC_ASSERT_SAME(a_pos_saturates, clk, rst_n, 1'b1, pos_reg <= FrameLenPos)
    `CRC16CFC_ASSERT_NEXT(a_burst_end_clears, clk, rst_n, last_take,
                          pos_reg == '0 && crc_reg == 16'h0000 && !mismatch_reg)
    `CRC16CFC_ASSERT_NEXT(a_burst_end_reports, clk, rst_n, last_take, out_valid_reg)
    `CRC16CFC_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
                          out_valid_reg && !out_ch.ready, !in_ch.ready)
    `CRC16CFC_ASSERT_SAME(a_short_before_full, clk, rst_n,
                          last_take && pos_upd < FrameLenPos,
                          status == crc16cfc_pkg::STATUS_SHORT)

endmodule
